>>> rtl/sirt_pkg.sv
`default_nettype none

package sirt_pkg;

   // Field widths of the channels.
   localparam int VALUE_W    = 32;
   localparam int CHAR_W     = 8;
   localparam int WORD_W     = 64;
   localparam int NUM_WORDS  = 8;
   localparam int CSR_ADDR_W = 3;

   // Glyph table geometry.
   localparam int MAX_GLYPHS  = 64;
   localparam int GLYPH_IDX_W = 6;
   localparam int RADIX_W     = 7;
   localparam int SEEN_IDX_W  = 7;
   localparam int SEEN_W      = 128;

   // Digit storage and counting.
   localparam int DIGIT_W     = 6;
   localparam int DIGIT_SLOTS = 32;
   localparam int COUNT_W     = 6;

   // The divider consumes the dividend one byte per cycle.
   localparam int CHUNK_W     = 8;
   localparam int CHUNKS      = VALUE_W / CHUNK_W;
   localparam int CHUNK_CNT_W = 3;

   // Character codes.
   localparam logic [CHAR_W-1:0] GLYPH_LO   = 8'd33;
   localparam logic [CHAR_W-1:0] GLYPH_HI   = 8'd126;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

   // Status of the glyph table as seen by the sequencer.
   typedef struct packed {
      logic               busy;
      logic               ok;
      logic [RADIX_W-1:0] radix;
   } tab_status_type;

   // Control of the digit stack.
   typedef struct packed {
      logic push;
      logic pop;
   } stk_ctl_type;

   // Status of the serial divider.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

>>> rtl/sirt_if.sv
`default_nettype none

// Input channel: one signed value per word.
interface sirt_req_if;
   import sirt_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value;
   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

// Result channel: one character per word.
interface sirt_rsp_if;
   import sirt_pkg::*;
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_out;
   logic              is_last;
   logic              bad_base;
   modport source (output valid, output char_out, output is_last, output bad_base,
                   input ready);
   modport sink (input valid, input char_out, input is_last, input bad_base,
                 output ready);
endinterface

// Register write channel.
interface sirt_csr_if;
   import sirt_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [WORD_W-1:0]     data;
   modport source (output valid, output addr, output data, input ready);
   modport sink (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/sirt_glyph_tab.sv
`default_nettype none

module sirt_glyph_tab (
   input  wire logic                            clock,
   input  wire logic                            reset,
   sirt_csr_if.sink                             csr,
   input  wire logic [sirt_pkg::DIGIT_W-1:0]    lookup_digit,
   output logic      [sirt_pkg::CHAR_W-1:0]     lookup_glyph,
   output sirt_pkg::tab_status_type             status
);
   import sirt_pkg::*;

   logic [NUM_WORDS-1:0][WORD_W-1:0]      glyph_ff, glyph_in;
   logic [MAX_GLYPHS-1:0][CHAR_W-1:0]     glyph_bytes;
   logic                                  busy_ff, busy_in;
   logic                                  ok_ff, ok_in;
   logic [RADIX_W-1:0]                    idx_ff, idx_in;
   logic [RADIX_W-1:0]                    radix_ff, radix_in;
   logic [SEEN_W-1:0]                     seen_ff, seen_in;
   logic [CHAR_W-1:0]                     scan_glyph;
   logic                                  glyph_bad;

   assign glyph_bytes  = glyph_ff;
   assign lookup_glyph = glyph_bytes[lookup_digit];
   assign csr.ready    = 1'b1;
   assign status       = '{busy: busy_ff, ok: ok_ff, radix: radix_ff};

   // The glyph under the scan pointer, and whether it spoils the table.
   assign scan_glyph = glyph_bytes[idx_ff[GLYPH_IDX_W-1:0]];
   assign glyph_bad  = (scan_glyph < GLYPH_LO) || (scan_glyph > GLYPH_HI) ||
                       (scan_glyph == CHAR_PLUS) || (scan_glyph == CHAR_MINUS) ||
                       seen_ff[scan_glyph[SEEN_IDX_W-1:0]];

   // A register write restarts the scan; the scan then checks one glyph a cycle,
   // marking each glyph it has seen so that a repeat is caught.
   always_comb begin
      glyph_in = glyph_ff;
      busy_in  = busy_ff;
      ok_in    = ok_ff;
      idx_in   = idx_ff;
      radix_in = radix_ff;
      seen_in  = seen_ff;
      if (csr.valid) begin
         glyph_in[csr.addr] = csr.data;
         busy_in            = 1'b1;
         ok_in              = 1'b0;
         idx_in             = '0;
         seen_in            = '0;
      end else if (busy_ff) begin
         if (scan_glyph == CHAR_NONE) begin
            busy_in  = 1'b0;
            ok_in    = (idx_ff >= RADIX_W'(2));
            radix_in = idx_ff;
         end else if (glyph_bad) begin
            busy_in = 1'b0;
            ok_in   = 1'b0;
         end else begin
            seen_in[scan_glyph[SEEN_IDX_W-1:0]] = 1'b1;
            if (idx_ff == RADIX_W'(MAX_GLYPHS - 1)) begin
               busy_in  = 1'b0;
               ok_in    = 1'b1;
               radix_in = RADIX_W'(MAX_GLYPHS);
            end else begin
               idx_in = idx_ff + RADIX_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         glyph_ff <= '0;
         busy_ff  <= 1'b0;
         ok_ff    <= 1'b0;
      end else begin
         glyph_ff <= glyph_in;
         busy_ff  <= busy_in;
         ok_ff    <= ok_in;
      end
      idx_ff   <= idx_in;
      radix_ff <= radix_in;
      seen_ff  <= seen_in;
   end

endmodule

`default_nettype wire

>>> rtl/sirt_div.sv
`default_nettype none

module sirt_div (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [sirt_pkg::VALUE_W-1:0]    dividend,
   input  wire logic [sirt_pkg::RADIX_W-1:0]    radix,
   output logic      [sirt_pkg::VALUE_W-1:0]    quotient,
   output logic      [sirt_pkg::DIGIT_W-1:0]    remainder,
   output sirt_pkg::div_status_type             status
);
   import sirt_pkg::*;

   logic [VALUE_W-1:0]     quo_ff, quo_in;
   logic [DIGIT_W-1:0]     rem_ff, rem_in;
   logic [CHUNK_CNT_W-1:0] cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CHUNK_CNT_W-1:0] lead;
   logic [VALUE_W-1:0]     aligned;
   logic [CHUNK_W-1:0]     in_byte;
   logic [CHUNK_W-1:0]     q_bits;
   logic [DIGIT_W-1:0]     step_rem;

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign status    = '{busy: busy_ff, done: done_ff};

   // Skip leading zero bytes: count the bytes up to the highest non-zero one
   // and move that byte to the top of the shift register.
   always_comb begin
      lead = CHUNK_CNT_W'(1);
      for (int k = 0; k < CHUNKS; k++) begin
         if (dividend[k*CHUNK_W +: CHUNK_W] != '0) begin
            lead = CHUNK_CNT_W'(k + 1);
         end
      end
      aligned = dividend << (CHUNK_W * (CHUNKS - int'(lead)));
   end

   // Eight restoring steps on the byte at the top of the register.
   assign in_byte = quo_ff[VALUE_W-1 -: CHUNK_W];

   always_comb begin
      logic [DIGIT_W:0] trial;
      step_rem = rem_ff;
      q_bits   = '0;
      for (int i = CHUNK_W - 1; i >= 0; i--) begin
         trial = {step_rem, in_byte[i]};
         if (trial >= radix) begin
            step_rem  = DIGIT_W'(trial - radix);
            q_bits[i] = 1'b1;
         end else begin
            step_rem  = trial[DIGIT_W-1:0];
         end
      end
   end

   // Quotient bytes shift in at the bottom as dividend bytes leave the top.
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = aligned;
         rem_in  = '0;
         cnt_in  = lead;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[VALUE_W-CHUNK_W-1:0], q_bits};
         rem_in = step_rem;
         cnt_in = cnt_ff - CHUNK_CNT_W'(1);
         if (cnt_ff == CHUNK_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

endmodule

`default_nettype wire

>>> rtl/sirt_stack.sv
`default_nettype none

module sirt_stack (
   input  wire logic                            clock,
   input  wire sirt_pkg::stk_ctl_type           ctl,
   input  wire logic [sirt_pkg::DIGIT_W-1:0]    push_digit,
   output logic      [sirt_pkg::DIGIT_W-1:0]    top_digit
);
   import sirt_pkg::*;

   logic [DIGIT_SLOTS-1:0][DIGIT_W-1:0] stk_ff, stk_in;

   assign top_digit = stk_ff[0];

   // Digits arrive least significant first and leave most significant first,
   // so the store is a shift register that moves one way on a push and the
   // other on a pop.
   always_comb begin
      stk_in = stk_ff;
      if (ctl.push) begin
         stk_in = {stk_ff[DIGIT_SLOTS-2:0], push_digit};
      end else if (ctl.pop) begin
         stk_in = {DIGIT_W'(0), stk_ff[DIGIT_SLOTS-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      stk_ff <= stk_in;
   end

endmodule

`default_nettype wire

>>> rtl/signed_integer_to_radix_text.sv
// Converts a signed 32-bit value to text in the radix set by a glyph table.
// The table is written as eight 64-bit words on the csr_ channel, glyph 0 in
// the low byte of word 0; the radix is the count of glyphs before the first
// zero byte. After each write the table is scanned at one glyph per cycle, and
// no value is taken on req_ until the scan is done. Each value on req_ gives a
// run of words on rsp_: a minus sign for a negative value, then the digit
// glyphs most significant first, is_last on the final one. A table that is too
// short, holds an unprintable, plus, minus or repeated glyph gives one word
// with bad_base set and char_out zero. Digits come from a divider that takes
// one byte of the quotient per cycle, skipping leading zero bytes; the
// characters then go out one per cycle while rsp_ takes them. A stalled rsp_
// holds its word; the division carries on, but no further character is sent
// and no value is taken on req_ until that word is taken. Reset clears the
// table to zero, which is an invalid table.
`default_nettype none

module signed_integer_to_radix_text (
   input  wire logic clock,
   input  wire logic reset,
   sirt_req_if.sink  req_ch,
   sirt_rsp_if.source rsp_ch,
   sirt_csr_if.sink  csr_ch
);
   import sirt_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV  = 2'd1;
   localparam logic [1:0] S_EMIT = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]   char_ff, char_in;
   logic                last_ff, last_in;
   logic                bad_ff, bad_in;

   tab_status_type      tab;
   div_status_type      div_st;
   stk_ctl_type         stk_ctl;
   logic                div_start;
   logic [VALUE_W-1:0]  div_dividend;
   logic [VALUE_W-1:0]  div_quotient;
   logic [DIGIT_W-1:0]  div_remainder;
   logic [DIGIT_W-1:0]  top_digit;
   logic [CHAR_W-1:0]   top_glyph;
   logic [VALUE_W-1:0]  mag;
   logic                rsp_free;
   logic                accept;

   sirt_glyph_tab u_tab (
      .clock        (clock),
      .reset        (reset),
      .csr          (csr_ch),
      .lookup_digit (top_digit),
      .lookup_glyph (top_glyph),
      .status       (tab)
   );

   sirt_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .radix     (tab.radix),
      .quotient  (div_quotient),
      .remainder (div_remainder),
      .status    (div_st)
   );

   sirt_stack u_stack (
      .clock      (clock),
      .ctl        (stk_ctl),
      .push_digit (div_remainder),
      .top_digit  (top_digit)
   );

   // Handshakes.
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE) && !tab.busy && rsp_free;
   assign accept       = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.char_out = char_ff;
   assign rsp_ch.is_last  = last_ff;
   assign rsp_ch.bad_base = bad_ff;

   // Magnitude as unsigned, so the most negative value gives 2^31.
   assign mag = req_ch.value[VALUE_W-1] ? (VALUE_W'(0) - $unsigned(req_ch.value))
                                        : $unsigned(req_ch.value);
   assign div_dividend = (state_ff == S_IDLE) ? mag : div_quotient;

   // Sequencer: answer a bad table at once; else divide until the quotient is zero, then pop the digits out.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      char_in      = char_ff;
      last_in      = last_ff;
      bad_in       = bad_ff;
      div_start    = 1'b0;
      stk_ctl      = '{push: 1'b0, pop: 1'b0};
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (!tab.ok) begin
                  rsp_valid_in = 1'b1;
                  char_in      = CHAR_NONE;
                  last_in      = 1'b1;
                  bad_in       = 1'b1;
               end else begin
                  if (req_ch.value[VALUE_W-1]) begin
                     rsp_valid_in = 1'b1;
                     char_in      = CHAR_MINUS;
                     last_in      = 1'b0;
                     bad_in       = 1'b0;
                  end
                  div_start = 1'b1;
                  count_in  = '0;
                  state_in  = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (div_st.done) begin
               stk_ctl.push = 1'b1;
               count_in     = count_ff + COUNT_W'(1);
               if (div_quotient == '0) begin
                  state_in = S_EMIT;
               end else begin
                  div_start = 1'b1;
               end
            end
         end
         S_EMIT: begin
            if (rsp_free) begin
               stk_ctl.pop  = 1'b1;
               rsp_valid_in = 1'b1;
               char_in      = top_glyph;
               last_in      = (count_ff == COUNT_W'(1));
               bad_in       = 1'b0;
               count_in     = count_ff - COUNT_W'(1);
               if (count_ff == COUNT_W'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      char_ff <= char_in;
      last_ff <= last_in;
      bad_ff  <= bad_in;
   end

endmodule

`default_nettype wire

>>> tb/sv/tb_signed_integer_to_radix_text.sv
`timescale 1ns / 100ps

module tb_signed_integer_to_radix_text;
   import sirt_pkg::*;

   localparam int HALF_PERIOD     = 10;
   localparam int RESET_CYCLES    = 12;
   localparam int QUIET_LIMIT     = 4000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int DRAIN_CYCLES    = 200;
   localparam int HOLD_CYCLES     = 500;
   localparam int TABLES_PER_MODE = 4;
   localparam int ITEMS_PER_TABLE = 26;
   localparam int IDLE_MODES      = 4;
   localparam int GLYPHS_PER_WORD = WORD_W / CHAR_W;

   // Idling per mode: none, sender only, receiver only, both.
   localparam int unsigned SEND_IDLE_PCT [IDLE_MODES] = '{0, 51, 0, 34};
   localparam int unsigned RSP_STALL_PCT [IDLE_MODES] = '{0, 0, 51, 34};

   // Register indexes of the glyph table words.
   typedef enum logic [CSR_ADDR_W-1:0] {
      GLYPH_WORD_0, GLYPH_WORD_1, GLYPH_WORD_2, GLYPH_WORD_3,
      GLYPH_WORD_4, GLYPH_WORD_5, GLYPH_WORD_6, GLYPH_WORD_7
   } glyph_word_type;

   // Ways of making a glyph table invalid.
   typedef enum int {
      SPOIL_EMPTY, SPOIL_SHORT, SPOIL_PLUS, SPOIL_MINUS,
      SPOIL_SPACE, SPOIL_DEL, SPOIL_HIGH, SPOIL_REPEAT
   } spoil_type;

   typedef logic [CHAR_W-1:0] glyph_set_type [MAX_GLYPHS];

   typedef struct {
      logic [CHAR_W-1:0] glyph;
      logic              last;
      logic              bad;
   } text_char_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sirt_req_if req_if ();
   sirt_rsp_if rsp_if ();
   sirt_csr_if csr_if ();

   signed_integer_to_radix_text dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   logic signed [VALUE_W-1:0] pending_values [$];
   text_char_type             expected_text [$];
   logic [CHAR_W-1:0]         glyph_copy [MAX_GLYPHS];
   int unsigned               send_idle_pct = 0;
   int unsigned               rsp_stall_pct = 0;
   int unsigned               mismatch_count = 0;
   int unsigned               quiet_cycles = 0;
   logic                      req_taken = 1'b0;
   logic                      hold_request = 1'b0;
   logic                      rsp_held = 1'b0;

   // Free-running clock.
   initial begin
      forever #(HALF_PERIOD) clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // Radix of the table as currently loaded, or zero if the table is invalid.
   function automatic int unsigned glyph_radix();
      int unsigned n;
      n = 0;
      while (n < MAX_GLYPHS && glyph_copy[n] != CHAR_NONE) n++;
      if (n < 2) return 0;
      for (int a = 0; a < n; a++) begin
         if (glyph_copy[a] < GLYPH_LO || glyph_copy[a] > GLYPH_HI ||
             glyph_copy[a] == CHAR_PLUS || glyph_copy[a] == CHAR_MINUS) return 0;
         for (int b = a + 1; b < n; b++) begin
            if (glyph_copy[b] == glyph_copy[a]) return 0;
         end
      end
      return n;
   endfunction

   // Works out the characters that one value turns into and queues them.
   task automatic spell_number(input logic [VALUE_W-1:0] raw);
      int unsigned        radix;
      logic [VALUE_W-1:0] mag;
      logic [DIGIT_W-1:0] digits [$];
      radix = glyph_radix();
      if (radix == 0) begin
         expected_text.push_back('{CHAR_NONE, 1'b1, 1'b1});
         return;
      end
      // The most negative value wraps to a true magnitude of 2^31.
      mag = raw[VALUE_W-1] ? -raw : raw;
      if (mag == 0) begin
         expected_text.push_back('{glyph_copy[0], 1'b1, 1'b0});
         return;
      end
      while (mag != 0) begin
         digits.push_front(DIGIT_W'(mag % radix));
         mag = mag / radix;
      end
      if (raw[VALUE_W-1]) expected_text.push_back('{CHAR_MINUS, 1'b0, 1'b0});
      foreach (digits[i]) begin
         expected_text.push_back('{glyph_copy[digits[i]], i == digits.size() - 1, 1'b0});
      end
   endtask

   function automatic glyph_set_type glyph_set_from_text(input string text);
      glyph_set_type set;
      for (int i = 0; i < MAX_GLYPHS; i++) begin
         set[i] = (i < text.len()) ? text[i] : CHAR_NONE;
      end
      return set;
   endfunction

   // A valid table of distinct printable glyphs, with junk after the terminator.
   function automatic glyph_set_type random_glyph_set(input int unsigned radix);
      glyph_set_type     set;
      logic [CHAR_W-1:0] pool [$];
      int unsigned       pick;
      for (int g = GLYPH_LO; g <= GLYPH_HI; g++) begin
         if (g != CHAR_PLUS && g != CHAR_MINUS) pool.push_back(CHAR_W'(g));
      end
      for (int i = 0; i < MAX_GLYPHS; i++) begin
         if (i < radix) begin
            pick = $urandom_range(0, pool.size() - 1);
            set[i] = pool[pick];
            pool.delete(pick);
         end else if (i == radix) begin
            set[i] = CHAR_NONE;
         end else begin
            set[i] = CHAR_W'($urandom_range(0, 255));
         end
      end
      return set;
   endfunction

   // Breaks a valid table of the given radix in the way asked for.
   function automatic glyph_set_type spoil_glyph_set(input glyph_set_type set,
                                                     input int unsigned radix,
                                                     input spoil_type kind);
      int unsigned pos;
      pos = $urandom_range(0, radix - 1);
      case (kind)
         SPOIL_EMPTY:  set[0] = CHAR_NONE;
         SPOIL_SHORT:  set[1] = CHAR_NONE;
         SPOIL_PLUS:   set[pos] = CHAR_PLUS;
         SPOIL_MINUS:  set[pos] = CHAR_MINUS;
         SPOIL_SPACE:  set[pos] = CHAR_W'(GLYPH_LO - 1);
         SPOIL_DEL:    set[pos] = CHAR_W'(GLYPH_HI + 1);
         SPOIL_HIGH:   set[pos] = CHAR_W'($urandom_range(128, 255));
         SPOIL_REPEAT: begin
            pos = $urandom_range(1, radix - 1);
            set[pos] = set[$urandom_range(0, pos - 1)];
         end
         default: ;
      endcase
      return set;
   endfunction

   // Values spread over digit counts, signs and the extremes.
   function automatic logic signed [VALUE_W-1:0] random_number(input int unsigned radix);
      logic [VALUE_W-1:0] bits;
      longint             power;
      int unsigned        base;
      base = (radix < 2) ? 10 : radix;
      bits = $urandom;
      case ($urandom_range(0, 5))
         0, 1: ;
         2: bits = $urandom_range(0, 600) - 300;
         3: begin
            bits = bits >> $urandom_range(0, 31);
            if ($urandom_range(0, 1)) bits = -bits;
         end
         4: begin
            case ($urandom_range(0, 3))
               0: bits = 32'h8000_0000;
               1: bits = 32'h7FFF_FFFF;
               2: bits = 32'h0000_0000;
               default: bits = 32'h8000_0001;
            endcase
         end
         default: begin
            // Near a power of the radix, where the digit count steps.
            power = 1;
            repeat ($urandom_range(1, 31)) begin
               if (power * base <= 64'h7FFF_FFFF) power = power * base;
            end
            bits = power[VALUE_W-1:0] + $urandom_range(0, 2) - 1;
            if ($urandom_range(0, 1)) bits = -bits;
         end
      endcase
      return bits;
   endfunction

   // Writes all eight table words back to back.
   task automatic load_glyph_table(input glyph_set_type set);
      logic [WORD_W-1:0] word;
      for (int w = 0; w < NUM_WORDS; w++) begin
         for (int b = 0; b < GLYPHS_PER_WORD; b++) begin
            word[CHAR_W*b +: CHAR_W] = set[GLYPHS_PER_WORD*w + b];
         end
         @(negedge clock);
         csr_if.valid <= 1'b1;
         csr_if.addr  <= glyph_word_type'(w);
         csr_if.data  <= word;
         @(posedge clock);
         while (!csr_if.ready) @(posedge clock);
      end
      @(negedge clock);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Waits until every value has been taken and every character has come back.
   task automatic wait_idle();
      do @(posedge clock);
      while (pending_values.size() != 0 || req_if.valid || expected_text.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Value driver: offers the next word once the current one is taken.
   always @(negedge clock) begin
      if (reset !== 1'b0) begin
         req_if.valid <= 1'b0;
         req_if.value <= '0;
      end else if (!req_if.valid || req_taken) begin
         if (pending_values.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_if.valid <= 1'b1;
            req_if.value <= pending_values.pop_front();
         end else begin
            req_if.valid <= 1'b0;
            req_if.value <= $urandom;
         end
      end
   end

   // Character receiver: random stalls, plus the long hold-off when asked.
   always @(negedge clock) begin
      if (reset !== 1'b0 || rsp_held) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // Holds the receiver off long enough for the block to back up its input.
   initial begin : rsp_hold_off
      wait (hold_request);
      @(posedge clock);
      rsp_held = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_held = 1'b0;
   end

   // Monitor: tracks the table, predicts on each value and checks each character.
   always @(posedge clock) begin : monitor
      text_char_type due;
      if (reset) begin
         req_taken <= 1'b0;
         foreach (glyph_copy[i]) glyph_copy[i] = CHAR_NONE;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         if (csr_if.valid && csr_if.ready) begin
            for (int b = 0; b < GLYPHS_PER_WORD; b++) begin
               glyph_copy[int'(csr_if.addr)*GLYPHS_PER_WORD + b] =
                  csr_if.data[CHAR_W*b +: CHAR_W];
            end
         end
         if (req_if.valid && req_if.ready) spell_number(req_if.value);
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_text.size() == 0) begin
               report_mismatch($sformatf("unexpected word char=%02h last=%b bad=%b",
                  rsp_if.char_out, rsp_if.is_last, rsp_if.bad_base));
            end else begin
               due = expected_text.pop_front();
               if (rsp_if.char_out !== due.glyph)
                  report_mismatch($sformatf("char_out %02h, wanted %02h",
                     rsp_if.char_out, due.glyph));
               if (rsp_if.is_last !== due.last)
                  report_mismatch($sformatf("is_last %b, wanted %b",
                     rsp_if.is_last, due.last));
               if (rsp_if.bad_base !== due.bad)
                  report_mismatch($sformatf("bad_base %b, wanted %b",
                     rsp_if.bad_base, due.bad));
            end
         end
      end
   end

   // Watchdog: ends the run if no word moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      glyph_set_type set;
      int unsigned   radix;
      csr_if.valid = 1'b0;
      csr_if.addr  = GLYPH_WORD_0;
      csr_if.data  = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // The table comes out of reset empty, so the first value is refused.
      pending_values.push_back(-32'sd5);
      wait_idle();

      // Decimal: zero, unit values, both extremes and a digit-count step.
      load_glyph_table(glyph_set_from_text("0123456789"));
      pending_values.push_back(32'sd0);
      pending_values.push_back(32'sd1);
      pending_values.push_back(-32'sd1);
      pending_values.push_back(32'sh7FFF_FFFF);
      pending_values.push_back(32'sh8000_0000);
      pending_values.push_back(-32'sd10);
      wait_idle();

      // Binary: the longest texts.
      load_glyph_table(glyph_set_from_text("01"));
      pending_values.push_back(32'sh8000_0000);
      pending_values.push_back(32'sh7FFF_FFFF);
      pending_values.push_back(32'sd0);
      pending_values.push_back(32'sh5555_5555);
      wait_idle();

      // A full table with no terminator gives radix 64.
      load_glyph_table(glyph_set_from_text(
         "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz@#"));
      pending_values.push_back(32'sh8000_0000);
      pending_values.push_back(32'sh7FFF_FFFF);
      pending_values.push_back(32'sd63);
      pending_values.push_back(-32'sd64);
      wait_idle();

      // Hexadecimal with random glyphs and junk past the terminator.
      load_glyph_table(random_glyph_set(16));
      pending_values.push_back(32'shDEAD_BEEF);
      wait_idle();

      // Each kind of broken table but the empty one, one value apiece.
      for (int k = SPOIL_SHORT; k <= SPOIL_REPEAT; k++) begin
         load_glyph_table(spoil_glyph_set(glyph_set_from_text("0123456789"), 10,
                                          spoil_type'(k)));
         pending_values.push_back(random_number(10));
         wait_idle();
      end

      // Random tables and values under each idling mode.
      for (int mode = 0; mode < IDLE_MODES; mode++) begin
         send_idle_pct = SEND_IDLE_PCT[mode];
         rsp_stall_pct = RSP_STALL_PCT[mode];
         for (int t = 0; t < TABLES_PER_MODE; t++) begin
            case ($urandom_range(0, 7))
               0: radix = 2;
               1: radix = MAX_GLYPHS;
               default: radix = $urandom_range(3, MAX_GLYPHS - 1);
            endcase
            set = random_glyph_set(radix);
            if (!(mode == 0 && t == 0) && $urandom_range(0, 7) == 0) begin
               set = spoil_glyph_set(set, radix, spoil_type'($urandom_range(0, 7)));
            end
            load_glyph_table(set);
            if (mode == 0 && t == 0) hold_request = 1'b1;
            repeat (ITEMS_PER_TABLE) pending_values.push_back(random_number(radix));
            wait_idle();
         end
      end

      // Let anything stray drain out before the verdict.
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_text.size() != 0)
         report_mismatch($sformatf("%0d characters never arrived", expected_text.size()));
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> signed_integer_to_radix_text.f
rtl/sirt_pkg.sv
rtl/sirt_if.sv
rtl/sirt_glyph_tab.sv
rtl/sirt_div.sv
rtl/sirt_stack.sv
rtl/signed_integer_to_radix_text.sv
tb/sv/tb_signed_integer_to_radix_text.sv
